>>> hw/rtl/assert_macros.svh
// Assertion helpers used by the top-level RTL file.
// Each check is sampled on the rising edge of clk and is ignored while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that a condition holds at every clock edge.
`define ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed: expression does not hold");

// Check that when a trigger holds, a result holds in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_ALWAYS(lbl, expr)
`define ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

>>> hw/rtl/pn3o_pkg.sv
package pn3o_pkg;

    // Fixed-point format and field widths
    localparam int FRAC_W     = 16;
    localparam int COORD_W    = 24;
    localparam int SCOORD_W   = 31;
    localparam int IDX_W      = 8;
    localparam int VAL_W      = 22;
    localparam int NOISE_W    = 17;
    localparam int CFG_W      = 4;
    localparam int OCT_W      = 3;
    localparam int MAX_OCT    = 8;
    localparam int DIV_STEPS  = 16;
    localparam int TABLE_SIZE = 256;

    // Datapath operation codes
    localparam logic [3:0] OP_NOP     = 4'd0;
    localparam logic [3:0] OP_TWRITE  = 4'd1;
    localparam logic [3:0] OP_CAPTURE = 4'd2;
    localparam logic [3:0] OP_FMUL    = 4'd3;
    localparam logic [3:0] OP_FCOMB   = 4'd4;
    localparam logic [3:0] OP_RD1     = 4'd5;
    localparam logic [3:0] OP_RD2     = 4'd6;
    localparam logic [3:0] OP_RD3     = 4'd7;
    localparam logic [3:0] OP_GRAD    = 4'd8;
    localparam logic [3:0] OP_LU      = 4'd9;
    localparam logic [3:0] OP_LV      = 4'd10;
    localparam logic [3:0] OP_LW      = 4'd11;
    localparam logic [3:0] OP_ACC     = 4'd12;
    localparam logic [3:0] OP_DIVI    = 4'd13;
    localparam logic [3:0] OP_DIVS    = 4'd14;
    localparam logic [3:0] OP_OUT     = 4'd15;

    // Command from controller to datapath
    typedef struct packed {
        logic [3:0]       op;
        logic [1:0]       sel;
        logic [1:0]       step;
        logic [2:0]       corner;
        logic [OCT_W-1:0] oct;
    } dp_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic out_free;
    } dp_stat_t;

endpackage

>>> hw/rtl/pn3o_ctrl.sv
module pn3o_ctrl
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic                    in_op,
    output logic                    in_ready,
    input  logic                    cfg_we,
    input  logic [pn3o_pkg::CFG_W-1:0] cfg_wdata,
    input  pn3o_pkg::dp_stat_t      stat,
    output pn3o_pkg::dp_cmd_t       cmd
);
    import pn3o_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_FMUL  = 4'd1;
    localparam logic [3:0] S_FCOMB = 4'd2;
    localparam logic [3:0] S_RD1   = 4'd3;
    localparam logic [3:0] S_RD2   = 4'd4;
    localparam logic [3:0] S_RD3   = 4'd5;
    localparam logic [3:0] S_GRAD  = 4'd6;
    localparam logic [3:0] S_LU    = 4'd7;
    localparam logic [3:0] S_LV    = 4'd8;
    localparam logic [3:0] S_LW    = 4'd9;
    localparam logic [3:0] S_ACC   = 4'd10;
    localparam logic [3:0] S_DIVI  = 4'd11;
    localparam logic [3:0] S_DIVS  = 4'd12;
    localparam logic [3:0] S_OUT   = 4'd13;

    logic [3:0]       state_reg, state_next;
    logic [1:0]       sel_reg, sel_next;
    logic [1:0]       step_reg, step_next;
    logic [2:0]       corner_reg, corner_next;
    logic [OCT_W-1:0] oct_reg, oct_next;
    logic [3:0]       dcnt_reg, dcnt_next;
    logic [CFG_W-1:0] octaves_reg;
    logic [OCT_W-1:0] last_oct;

    // Clamp the octave count to 1..MAX_OCT, as an index of the last octave
    always_comb
    begin
        if (octaves_reg == '0)
            last_oct = '0;
        else if (octaves_reg > CFG_W'(MAX_OCT))
            last_oct = OCT_W'(MAX_OCT - 1);
        else
            last_oct = OCT_W'(octaves_reg - CFG_W'(1));
    end

    assign in_ready = (state_reg == S_IDLE);

    // Sequence one evaluation
    always_comb
    begin
        state_next  = state_reg;
        sel_next    = sel_reg;
        step_next   = step_reg;
        corner_next = corner_reg;
        oct_next    = oct_reg;
        dcnt_next   = dcnt_reg;
        cmd.op      = OP_NOP;
        cmd.sel     = sel_reg;
        cmd.step    = step_reg;
        cmd.corner  = corner_reg;
        cmd.oct     = oct_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_op)
                    begin
                        cmd.op     = OP_CAPTURE;
                        state_next = S_FMUL;
                        sel_next   = '0;
                        step_next  = '0;
                        oct_next   = '0;
                    end
                    else
                    begin
                        cmd.op = OP_TWRITE;
                    end
                end
            end
            S_FMUL:
            begin
                cmd.op = OP_FMUL;
                if (step_reg == 2'd3)
                    state_next = S_FCOMB;
                else
                    step_next = step_reg + 2'd1;
            end
            S_FCOMB:
            begin
                cmd.op = OP_FCOMB;
                if (sel_reg == 2'd2)
                begin
                    state_next  = S_RD1;
                    corner_next = '0;
                end
                else
                begin
                    sel_next   = sel_reg + 2'd1;
                    step_next  = '0;
                    state_next = S_FMUL;
                end
            end
            S_RD1:
            begin
                cmd.op     = OP_RD1;
                state_next = S_RD2;
            end
            S_RD2:
            begin
                cmd.op     = OP_RD2;
                state_next = S_RD3;
            end
            S_RD3:
            begin
                cmd.op     = OP_RD3;
                state_next = S_GRAD;
            end
            S_GRAD:
            begin
                cmd.op = OP_GRAD;
                if (corner_reg[0])
                    state_next = S_LU;
                else
                begin
                    corner_next = corner_reg + 3'd1;
                    state_next  = S_RD1;
                end
            end
            S_LU:
            begin
                cmd.op = OP_LU;
                if (corner_reg[1])
                    state_next = S_LV;
                else
                begin
                    corner_next = corner_reg + 3'd1;
                    state_next  = S_RD1;
                end
            end
            S_LV:
            begin
                cmd.op = OP_LV;
                if (corner_reg[2])
                    state_next = S_LW;
                else
                begin
                    corner_next = corner_reg + 3'd1;
                    state_next  = S_RD1;
                end
            end
            S_LW:
            begin
                cmd.op     = OP_LW;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.op = OP_ACC;
                if (oct_reg == last_oct)
                    state_next = S_DIVI;
                else
                begin
                    oct_next   = oct_reg + OCT_W'(1);
                    sel_next   = '0;
                    step_next  = '0;
                    state_next = S_FMUL;
                end
            end
            S_DIVI:
            begin
                cmd.op     = OP_DIVI;
                dcnt_next  = '0;
                state_next = S_DIVS;
            end
            S_DIVS:
            begin
                cmd.op = OP_DIVS;
                if (dcnt_reg == 4'(DIV_STEPS - 1))
                    state_next = S_OUT;
                else
                    dcnt_next = dcnt_reg + 4'd1;
            end
            S_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = OP_OUT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and the octave count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            sel_reg     <= '0;
            step_reg    <= '0;
            corner_reg  <= '0;
            oct_reg     <= '0;
            dcnt_reg    <= '0;
            octaves_reg <= CFG_W'(1);
        end
        else
        begin
            state_reg  <= state_next;
            sel_reg    <= sel_next;
            step_reg   <= step_next;
            corner_reg <= corner_next;
            oct_reg    <= oct_next;
            dcnt_reg   <= dcnt_next;
            if (cfg_we)
                octaves_reg <= cfg_wdata;
        end
    end

endmodule

>>> hw/rtl/pn3o_dp.sv
module pn3o_dp
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  pn3o_pkg::dp_cmd_t             cmd,
    output pn3o_pkg::dp_stat_t            stat,
    input  logic [pn3o_pkg::COORD_W-1:0]  coord_x,
    input  logic [pn3o_pkg::COORD_W-1:0]  coord_y,
    input  logic [pn3o_pkg::COORD_W-1:0]  coord_z,
    input  logic [pn3o_pkg::IDX_W-1:0]    table_index,
    input  logic [pn3o_pkg::IDX_W-1:0]    table_value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [pn3o_pkg::NOISE_W-1:0]  noise
);
    import pn3o_pkg::*;

    logic [IDX_W-1:0]    perm_mem [TABLE_SIZE];
    logic [IDX_W-1:0]    rdata_reg;
    logic [IDX_W-1:0]    rd_addr;

    logic [SCOORD_W-1:0] sx_reg, sy_reg, sz_reg;
    logic [FRAC_W-1:0]   fa_reg, fb_reg, fc_reg, fd_reg;
    logic [FRAC_W:0]     u_reg, v_reg, w_reg;
    logic signed [VAL_W-1:0] ga_reg, gb_reg, lx0_reg, lx1_reg, ly0_reg, ly1_reg, lw_reg;
    logic signed [23:0]  sum_reg;
    logic [17:0]         weight_reg;
    logic [17:0]         rem_reg;
    logic [DIV_STEPS-1:0] q_reg;
    logic                neg_reg, sat_reg;
    logic [NOISE_W-1:0]  noise_reg;
    logic                out_valid_reg;

    logic [FRAC_W-1:0]   tsel, fsrc;
    logic [FRAC_W:0]     s_op;
    logic signed [VAL_W-1:0] lerp_a, lerp_b, diff, mq, lerp_res;
    logic signed [17:0]  mul_a;
    logic signed [VAL_W-1:0] mul_b;
    logic signed [39:0]  prod, prod_adj;
    logic signed [22:0]  comb;
    logic [FRAC_W:0]     fade_val;
    logic signed [17:0]  fx, fy, fz, px, py, pz, gp, gq, gpn, gqn;
    logic [3:0]          hg;
    logic signed [18:0]  grad;
    logic signed [22:0]  acc_t, acc_v, acc_adj, acc_c;
    logic [17:0]         weight_inc;
    logic [18:0]         rem2;

    assign stat.out_free = !out_valid_reg || out_ready;
    assign out_valid     = out_valid_reg;
    assign noise         = noise_reg;

    // Select fraction and fade chain operand
    always_comb
    begin
        unique case (cmd.sel)
            2'd0:    tsel = sx_reg[FRAC_W-1:0];
            2'd1:    tsel = sy_reg[FRAC_W-1:0];
            default: tsel = sz_reg[FRAC_W-1:0];
        endcase
        unique case (cmd.step)
            2'd0:    fsrc = tsel;
            2'd1:    fsrc = fa_reg;
            2'd2:    fsrc = fb_reg;
            default: fsrc = fc_reg;
        endcase
    end

    // Select lerp operands
    always_comb
    begin
        unique case (cmd.op)
            OP_LV:
            begin
                lerp_a = lx0_reg;
                lerp_b = lx1_reg;
                s_op   = v_reg;
            end
            OP_LW:
            begin
                lerp_a = ly0_reg;
                lerp_b = ly1_reg;
                s_op   = w_reg;
            end
            default:
            begin
                lerp_a = ga_reg;
                lerp_b = gb_reg;
                s_op   = u_reg;
            end
        endcase
        diff = lerp_b - lerp_a;
    end

    // Shared multiplier with truncation toward zero
    always_comb
    begin
        if (cmd.op == OP_FMUL)
        begin
            mul_a = $signed({2'b00, tsel});
            mul_b = $signed({6'b0, fsrc});
        end
        else
        begin
            mul_a = $signed({1'b0, s_op});
            mul_b = diff;
        end
        prod     = 40'(mul_a) * 40'(mul_b);
        prod_adj = prod + ((prod < 0) ? 40'sd65535 : 40'sd0);
        mq       = prod_adj[37:16];
        lerp_res = lerp_a + mq;
    end

    // Combine fade terms and clamp to 0..ONE
    always_comb
    begin
        comb = $signed({7'b0, fd_reg}) * 23'sd6 - $signed({7'b0, fc_reg}) * 23'sd15
             + $signed({7'b0, fb_reg}) * 23'sd10;
        if (comb < 0)
            fade_val = '0;
        else if (comb > 23'sd65536)
            fade_val = 17'd65536;
        else
            fade_val = comb[FRAC_W:0];
    end

    // Table read address for the three chained lookups
    always_comb
    begin
        unique case (cmd.op)
            OP_RD2:  rd_addr = rdata_reg + sy_reg[23:16] + IDX_W'(cmd.corner[1]);
            OP_RD3:  rd_addr = rdata_reg + sz_reg[23:16] + IDX_W'(cmd.corner[2]);
            default: rd_addr = sx_reg[23:16] + IDX_W'(cmd.corner[0]);
        endcase
    end

    // Gradient dot product for the current corner
    always_comb
    begin
        fx = $signed({2'b00, sx_reg[FRAC_W-1:0]});
        fy = $signed({2'b00, sy_reg[FRAC_W-1:0]});
        fz = $signed({2'b00, sz_reg[FRAC_W-1:0]});
        px = cmd.corner[0] ? fx - 18'sd65536 : fx;
        py = cmd.corner[1] ? fy - 18'sd65536 : fy;
        pz = cmd.corner[2] ? fz - 18'sd65536 : fz;
        hg = rdata_reg[3:0];
        gp = (hg < 4'd8) ? px : py;
        if (hg < 4'd4)
            gq = py;
        else if (hg == 4'd12 || hg == 4'd14)
            gq = px;
        else
            gq = pz;
        gpn  = hg[0] ? -gp : gp;
        gqn  = hg[1] ? -gq : gq;
        grad = 19'(gpn) + 19'(gqn);
    end

    // Octave accumulate: map to 0..1, weight by 2^-i toward zero
    always_comb
    begin
        acc_t      = 23'(lw_reg) + 23'sd65536;
        acc_v      = (acc_t + ((acc_t < 0) ? 23'sd1 : 23'sd0)) >>> 1;
        acc_adj    = acc_v + ((acc_v < 0) ? ((23'sd1 <<< cmd.oct) - 23'sd1) : 23'sd0);
        acc_c      = acc_adj >>> cmd.oct;
        weight_inc = 18'd65536 >> cmd.oct;
        rem2       = {rem_reg, 1'b0};
    end

    // Permutation table and registered read
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_TWRITE)
            perm_mem[table_index] <= table_value;
        rdata_reg <= perm_mem[rd_addr];
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_CAPTURE:
            begin
                sx_reg     <= SCOORD_W'(coord_x);
                sy_reg     <= SCOORD_W'(coord_y);
                sz_reg     <= SCOORD_W'(coord_z);
                sum_reg    <= '0;
                weight_reg <= '0;
            end
            OP_FMUL:
            begin
                unique case (cmd.step)
                    2'd0:    fa_reg <= mq[FRAC_W-1:0];
                    2'd1:    fb_reg <= mq[FRAC_W-1:0];
                    2'd2:    fc_reg <= mq[FRAC_W-1:0];
                    default: fd_reg <= mq[FRAC_W-1:0];
                endcase
            end
            OP_FCOMB:
            begin
                unique case (cmd.sel)
                    2'd0:    u_reg <= fade_val;
                    2'd1:    v_reg <= fade_val;
                    default: w_reg <= fade_val;
                endcase
            end
            OP_GRAD:
            begin
                if (cmd.corner[0])
                    gb_reg <= VAL_W'(grad);
                else
                    ga_reg <= VAL_W'(grad);
            end
            OP_LU:
            begin
                if (cmd.corner[1])
                    lx1_reg <= lerp_res;
                else
                    lx0_reg <= lerp_res;
            end
            OP_LV:
            begin
                if (cmd.corner[2])
                    ly1_reg <= lerp_res;
                else
                    ly0_reg <= lerp_res;
            end
            OP_LW:
            begin
                lw_reg <= lerp_res;
            end
            OP_ACC:
            begin
                sum_reg    <= sum_reg + 24'(acc_c);
                weight_reg <= weight_reg + weight_inc;
                sx_reg     <= {sx_reg[SCOORD_W-2:0], 1'b0};
                sy_reg     <= {sy_reg[SCOORD_W-2:0], 1'b0};
                sz_reg     <= {sz_reg[SCOORD_W-2:0], 1'b0};
            end
            OP_DIVI:
            begin
                neg_reg <= (sum_reg <= 0);
                sat_reg <= (sum_reg >= $signed({6'b0, weight_reg}));
                rem_reg <= sum_reg[17:0];
                q_reg   <= '0;
            end
            OP_DIVS:
            begin
                if (rem2 >= {1'b0, weight_reg})
                begin
                    rem_reg <= 18'(rem2 - {1'b0, weight_reg});
                    q_reg   <= {q_reg[DIV_STEPS-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem2[17:0];
                    q_reg   <= {q_reg[DIV_STEPS-2:0], 1'b0};
                end
            end
            OP_OUT:
            begin
                if (neg_reg)
                    noise_reg <= '0;
                else if (sat_reg)
                    noise_reg <= 17'd65536;
                else
                    noise_reg <= {1'b0, q_reg};
            end
            default:
            begin
            end
        endcase
    end

    // Output valid: set on a new result, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.op == OP_OUT)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

endmodule

>>> hw/rtl/perlin_noise_3d_octaves_top.sv
// Channel   Dir  Bits  Contents
// s_axis    in   88    tdata: coord_x, coord_y, coord_z, table_index, table_value; tuser: op
// m_axis    out  24    tdata: noise (17 bits, upper bits zero)
// cfg       in   4     octave_count, written when cfg_we is high
//
// A load request writes one table entry. An evaluate request runs, for each octave,
// the fade chain on one shared multiplier, 8 corners of three chained table reads
// and seven lerps, framed by capture, a 16-step divider and the output load.
// The permutation table is a 256x8 memory with one write port and one registered read port, read one address a cycle.
// Reset clears control state only; the table holds garbage until loaded.
// A finished result waits in the output register; the next request is taken meanwhile.
`include "assert_macros.svh"

module perlin_noise_3d_octaves_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,   // coord_x, coord_y, coord_z, table_index, table_value
    input  logic        s_tuser,   // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // noise
    input  logic        cfg_we,
    input  logic [3:0]  cfg_wdata
);
    import pn3o_pkg::*;

    dp_cmd_t            cmd;
    dp_stat_t           stat;
    logic [NOISE_W-1:0] noise;

    pn3o_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_op     (s_tuser),
        .in_ready  (s_tready),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .stat      (stat),
        .cmd       (cmd)
    );

    pn3o_dp u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .coord_x     (s_tdata[23:0]),
        .coord_y     (s_tdata[47:24]),
        .coord_z     (s_tdata[71:48]),
        .table_index (s_tdata[79:72]),
        .table_value (s_tdata[87:80]),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .noise       (noise)
    );

    assign m_tdata = {7'b0, noise};

    // Checks
    `ASSERT_NEXT(a_busy_after_eval, s_tvalid && s_tready && s_tuser, !s_tready)
    `ASSERT_ALWAYS(a_noise_range, !m_tvalid || m_tdata[16:0] <= 17'd65536)
    `ASSERT_ALWAYS(a_no_overwrite, cmd.op != OP_OUT || stat.out_free)

endmodule
